// ----- hdl/pu_pkg.sv -----
// ----------------------------------------------------------------------------
// pu_pkg
// Shared types and constants for the permutation unranking pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package pu_pkg;

  // Longest permutation the datapath holds
  localparam int unsigned MAX_LEN   = 12;
  localparam int unsigned LEN_W     = 4;
  localparam int unsigned RANK_W    = 29;
  localparam int unsigned DIG_W     = 4;
  localparam int unsigned RECIP_W   = 32;
  localparam int unsigned PROD_W    = RANK_W + RECIP_W;
  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(MAX_LEN);

  typedef logic [DIG_W-1:0] digit_t;

  // One item moving down the pipeline
  typedef struct packed {
    logic                      valid;
    logic [LEN_W-1:0]          len;
    logic [RANK_W-1:0]         rank;
    logic                      wrapped;
    logic [MAX_LEN-1:0][DIG_W-1:0] digit;
    logic [MAX_LEN-1:0][DIG_W-1:0] val;
  } pu_item_t;

  // Serializer status seen by the pipeline control
  typedef struct packed {
    logic active;
    logic finishing;
  } pu_emit_st_t;

endpackage

`default_nettype wire

// ----- hdl/permutation_unrank_top.sv -----
// ----------------------------------------------------------------------------
// permutation_unrank_top
// Factorial-base (Lehmer code) permutation unranking.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_valid/cfg_data write the permutation length n (0 reads as 1, above
//   12 as 12); cfg_ready is always high. Write it only while idle.
//   Drive in_rank with start; the transaction is taken on an edge where
//   start is high and busy is low.
//   Each rank yields n results, one per cycle, marked by out_valid:
//   out_position 0..n-1, out_element, out_last on position n-1 and
//   out_rank_wrapped when the rank was at or above n! and reduced modulo n!.
//   From accept to the first result an item passes one entry register,
//   eleven two-register digit stages, eleven decode stages and the serializer.
//   Throughput: the pipeline takes one rank per cycle until a finished item
//   at its tail waits for the serializer; from then on the serializer sets the
//   pace, and busy holds the whole pipeline while it drains a result.
//   The receiver cannot stall; results are shown for exactly one cycle.
//   Reset empties the pipeline and sets n to 12.
// ----------------------------------------------------------------------------
`default_nettype none

module permutation_unrank_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [3:0]  cfg_data,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [28:0] in_rank,
  output logic             out_valid,
  output logic [3:0]       out_position,
  output logic [3:0]       out_element,
  output logic             out_last,
  output logic             out_rank_wrapped
);
  import pu_pkg::*;

  logic [LEN_W-1:0] perm_length_r;
  logic [LEN_W-1:0] len_eff;
  logic             advance;
  pu_item_t         entry_r;
  pu_item_t         entry_nxt;
  pu_item_t         div_q [MAX_LEN];
  pu_item_t         adj_q [MAX_LEN];
  pu_emit_st_t      emit_st;

  // Configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      perm_length_r <= LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      perm_length_r <= cfg_data;
    end
  end

  always_comb begin
    if (perm_length_r == '0) begin
      len_eff = LEN_W'(1);
    end else if (perm_length_r > LEN_W'(MAX_LEN)) begin
      len_eff = LEN_W'(MAX_LEN);
    end else begin
      len_eff = perm_length_r;
    end
  end

  // Hold the pipeline while the serializer owes results and the next item waits
  assign advance = !(adj_q[MAX_LEN-1].valid && emit_st.active && !emit_st.finishing);
  assign busy    = !advance;

  // Entry stage: the last digit is always zero, n = 1 wraps on any nonzero rank
  always_comb begin
    entry_nxt         = '0;
    entry_nxt.valid   = start;
    entry_nxt.len     = len_eff;
    entry_nxt.rank    = in_rank;
    entry_nxt.wrapped = (len_eff == LEN_W'(1)) && (in_rank != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r.valid <= 1'b0;
    end else if (advance) begin
      entry_r <= entry_nxt;
    end
  end

  assign div_q[0] = entry_r;

  // Digit extraction, one constant divisor per stage
  for (genvar i = 1; i < MAX_LEN; i++) begin : g_div
    pu_div_stage #(.IDX(i)) u_div (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (advance),
      .item_i (div_q[i-1]),
      .item_o (div_q[i])
    );
  end

  assign adj_q[0] = div_q[MAX_LEN-1];

  // Lehmer decode, one partner distance per stage
  for (genvar t = 1; t < MAX_LEN; t++) begin : g_adj
    pu_adjust_stage #(.STEP(t)) u_adj (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (advance),
      .item_i (adj_q[t-1]),
      .item_o (adj_q[t])
    );
  end

  // Serialize results
  pu_emit u_emit (
    .clk              (clk),
    .rst_n            (rst_n),
    .load             (advance && adj_q[MAX_LEN-1].valid),
    .item_i           (adj_q[MAX_LEN-1]),
    .status           (emit_st),
    .out_valid        (out_valid),
    .out_position     (out_position),
    .out_element      (out_element),
    .out_last         (out_last),
    .out_rank_wrapped (out_rank_wrapped)
  );

endmodule

`default_nettype wire

// ----- hdl/pu_div_stage.sv -----
// ----------------------------------------------------------------------------
// pu_div_stage
// One mixed-radix digit: divide the running rank by the constant IDX+1
// through a reciprocal multiply (first register) and a single correction
// step (second register). The remainder is the digit at lane IDX.
// ----------------------------------------------------------------------------
`default_nettype none

module pu_div_stage #(
  parameter int unsigned IDX = 1
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             en,
  input  wire pu_pkg::pu_item_t item_i,
  output pu_pkg::pu_item_t      item_o
);
  import pu_pkg::*;

  localparam int unsigned DIVISOR = IDX + 1;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_W) / DIVISOR);

  pu_item_t             mid_r;
  logic [PROD_W-1:0]    prod_r;
  pu_item_t             out_r;
  pu_item_t             out_nxt;

  logic [RANK_W-1:0]    q_est;
  logic [RANK_W-1:0]    q_back;
  logic [RANK_W-1:0]    rem_full;
  logic [4:0]           rem_est;
  logic                 fix;
  logic [4:0]           rem;
  logic [RANK_W-1:0]    quot;

  // Multiply by the reciprocal
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_r.valid <= 1'b0;
    end else if (en) begin
      mid_r  <= item_i;
      prod_r <= PROD_W'(item_i.rank) * PROD_W'(RECIP);
    end
  end

  // Correct the estimate by at most one
  always_comb begin
    q_est    = prod_r[PROD_W-1:RECIP_W];
    q_back   = q_est * RANK_W'(DIVISOR);
    rem_full = mid_r.rank - q_back;
    rem_est  = rem_full[4:0];
    fix      = (rem_est >= 5'(DIVISOR));
    rem      = fix ? (rem_est - 5'(DIVISOR)) : rem_est;
    quot     = q_est + RANK_W'(fix);
    out_nxt            = mid_r;
    out_nxt.rank       = quot;
    out_nxt.digit[IDX] = rem[DIG_W-1:0];
    out_nxt.val[IDX]   = rem[DIG_W-1:0];
    if (mid_r.len == LEN_W'(DIVISOR)) begin
      out_nxt.wrapped = (quot != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_r.valid <= 1'b0;
    end else if (en) begin
      out_r <= out_nxt;
    end
  end

  assign item_o = out_r;

endmodule

`default_nettype wire

// ----- hdl/pu_adjust_stage.sv -----
// ----------------------------------------------------------------------------
// pu_adjust_stage
// One step of the Lehmer decode: every lane whose partner STEP lanes
// further on is in range compares its value with that original digit
// and bumps it when the digit is not larger.
// ----------------------------------------------------------------------------
`default_nettype none

module pu_adjust_stage #(
  parameter int unsigned STEP = 1
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             en,
  input  wire pu_pkg::pu_item_t item_i,
  output pu_pkg::pu_item_t      item_o
);
  import pu_pkg::*;

  pu_item_t out_r;
  pu_item_t out_nxt;

  // Bump each lane whose partner is in range and not larger
  always_comb begin
    out_nxt = item_i;
    for (int l = 0; l < MAX_LEN - STEP; l++) begin
      if ((5'(l + STEP) < {1'b0, item_i.len}) &&
          (item_i.digit[l + STEP] <= item_i.val[l])) begin
        out_nxt.val[l] = item_i.val[l] + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_r.valid <= 1'b0;
    end else if (en) begin
      out_r <= out_nxt;
    end
  end

  assign item_o = out_r;

endmodule

`default_nettype wire

// ----- hdl/pu_emit.sv -----
// ----------------------------------------------------------------------------
// pu_emit
// Result serializer: holds one decoded permutation and sends one position
// per cycle, lane n-1-k carrying the element for position k.
// ----------------------------------------------------------------------------
`default_nettype none

module pu_emit (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                load,
  input  wire pu_pkg::pu_item_t    item_i,
  output pu_pkg::pu_emit_st_t      status,
  output logic                     out_valid,
  output logic [3:0]               out_position,
  output logic [3:0]               out_element,
  output logic                     out_last,
  output logic                     out_rank_wrapped
);
  import pu_pkg::*;

  logic                          active_r;
  logic [LEN_W-1:0]              pos_r;
  logic [LEN_W-1:0]              len_r;
  logic                          wrapped_r;
  logic [MAX_LEN-1:0][DIG_W-1:0] val_r;
  logic [LEN_W-1:0]              lane;
  logic                          finishing;

  assign finishing = active_r && (pos_r == len_r - 4'd1);
  assign lane      = len_r - 4'd1 - pos_r;

  // Load a transaction or advance the position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      pos_r    <= '0;
    end else if (load) begin
      active_r <= 1'b1;
      pos_r    <= '0;
    end else if (active_r) begin
      if (finishing) begin
        active_r <= 1'b0;
      end else begin
        pos_r <= pos_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      len_r     <= item_i.len;
      wrapped_r <= item_i.wrapped;
      val_r     <= item_i.val;
    end
  end

  assign status.active    = active_r;
  assign status.finishing = finishing;

  assign out_valid        = active_r;
  assign out_position     = pos_r;
  assign out_element      = val_r[lane];
  assign out_last         = finishing;
  assign out_rank_wrapped = wrapped_r;

endmodule

`default_nettype wire

// ----- dv/permutation_unrank_top_tb.sv -----
// ----------------------------------------------------------------------------
// permutation_unrank_top_tb
// Drives ranks through the unranking block under several permutation lengths
// and idle patterns, predicts each permutation from its Lehmer code, and
// checks every emitted position, element, last and wrap flag in order.
// ----------------------------------------------------------------------------
`default_nettype none

module permutation_unrank_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pu_pkg::*;

  localparam int unsigned DRAIN_CYCLES = 80;
  localparam int unsigned WATCHDOG_MAX = 20000;

  typedef struct packed {
    logic [3:0] position;
    logic [3:0] element;
    logic       last;
    logic       wrapped;
  } perm_entry_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [3:0]  cfg_data;
  logic        start;
  logic        busy;
  logic [28:0] in_rank;
  logic        out_valid;
  logic [3:0]  out_position;
  logic [3:0]  out_element;
  logic        out_last;
  logic        out_rank_wrapped;

  perm_entry_t expected_perm_q[$];
  logic [3:0]  length_reg;
  int          idle_pct;
  int          error_count;
  int          rank_count;
  int          entry_count;
  int          wrap_count;
  int          quiet_cycles;

  permutation_unrank_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data),
    .start            (start),
    .busy             (busy),
    .in_rank          (in_rank),
    .out_valid        (out_valid),
    .out_position     (out_position),
    .out_element      (out_element),
    .out_last         (out_last),
    .out_rank_wrapped (out_rank_wrapped)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic longint unsigned fact(int unsigned m);
    longint unsigned f;
    f = 1;
    for (int unsigned t = 2; t <= m; t++) f = f * t;
    return f;
  endfunction

  // Build the expected permutation for one rank under the current length
  function automatic void predict_permutation(logic [28:0] rank);
    int unsigned     n;
    longint unsigned total;
    longint unsigned rem;
    logic            wrap;
    logic [4:0]      dig [MAX_LEN];
    perm_entry_t     e;
    n = length_reg;
    if (n < 1) n = 1;
    if (n > MAX_LEN) n = MAX_LEN;
    total = fact(n);
    rem   = rank;
    wrap  = 1'b0;
    if (rem >= total) begin
      rem  = rem % total;
      wrap = 1'b1;
    end
    for (int unsigned k = 0; k < n; k++) begin
      dig[k] = 5'(rem / fact(n - 1 - k));
      rem    = rem % fact(n - 1 - k);
    end
    for (int k = n - 1; k > 0; k--) begin
      for (int j = k; j > 0; j--) begin
        if (dig[j-1] <= dig[k]) dig[k] = dig[k] + 1;
      end
    end
    for (int unsigned k = 0; k < n; k++) begin
      e.position = 4'(k);
      e.element  = dig[k][3:0];
      e.last     = (k == n - 1);
      e.wrapped  = wrap;
      expected_perm_q.push_back(e);
    end
    if (wrap) wrap_count++;
  endfunction

  // Compare each emitted entry with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      perm_entry_t got;
      perm_entry_t exp_e;
      got = '{out_position, out_element, out_last, out_rank_wrapped};
      if (expected_perm_q.size() == 0) begin
        $display("%0t: unexpected entry %p", $realtime, got);
        error_count++;
      end else begin
        exp_e = expected_perm_q.pop_front();
        entry_count++;
        if (got !== exp_e) begin
          $display("%0t: mismatch expected %p actual %p", $realtime, exp_e, got);
          error_count++;
        end
      end
    end
  end

  // Stop the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_MAX) begin
        $display("permutation_unrank_top_tb: FAIL");
        $finish;
      end
    end
  end

  // Send one rank, with random idle cycles ahead of it
  task automatic send_rank(logic [28:0] rank);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_rank <= rank;
    do @(posedge clk); while (busy);
    predict_permutation(rank);
    rank_count++;
  endtask

  // Hold until every expected entry has arrived, plus a settle margin
  task automatic wait_drained();
    start <= 1'b0;
    while (expected_perm_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_length(logic [3:0] len);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= len;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    length_reg = len;
  endtask

  function automatic logic [28:0] rand_rank();
    case ($urandom_range(3))
      0: return 29'($urandom);
      1: return 29'($urandom_range(479001599));
      default: begin
        int unsigned n;
        n = (length_reg < 1) ? 1 : (length_reg > MAX_LEN ? MAX_LEN : length_reg);
        return 29'($urandom % (fact(n) + 1));
      end
    endcase
  endfunction

  // Directed ranks at the reset length and at the length extremes
  task automatic test_directed();
    idle_pct = 0;
    send_rank(29'd0);
    send_rank(29'd479001599);
    send_rank(29'd479001600);
    send_rank(29'h1FFFFFFF);
    send_rank(29'h0AAAAAAA);
    send_rank(29'h15555555);
    write_length(4'd1);
    send_rank(29'd0);
    send_rank(29'd1);
    write_length(4'd0);
    send_rank(29'd0);
    send_rank(29'd5);
    write_length(4'd15);
    send_rank(29'd479001599);
    send_rank(29'd123456789);
    write_length(4'd2);
    send_rank(29'd0);
    send_rank(29'd1);
    send_rank(29'd2);
    write_length(4'd3);
    for (int r = 0; r < 7; r++) send_rank(29'(r));
  endtask

  // Random ranks over several lengths and idle patterns
  task automatic test_random();
    int pcts [4] = '{0, 46, 0, 6};
    logic [3:0] lens [6] = '{4'd12, 4'd4, 4'd7, 4'd1, 4'd13, 4'd10};
    for (int p = 0; p < 6; p++) begin
      write_length(lens[p]);
      idle_pct = pcts[p % 4];
      for (int i = 0; i < 22; i++) send_rank(rand_rank());
      if (p == 2) wait_drained();
    end
  endtask

  initial begin
    rst_n       = 1'b0;
    cfg_valid   = 1'b0;
    cfg_data    = '0;
    start       = 1'b0;
    in_rank     = '0;
    length_reg  = LEN_RESET;
    idle_pct    = 0;
    error_count = 0;
    rank_count  = 0;
    entry_count = 0;
    wrap_count  = 0;
    quiet_cycles = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random();
    wait_drained();
    $display("Covered %0d ranks, %0d permutation entries, %0d wrapped ranks, lengths 0..15.",
             rank_count, entry_count, wrap_count);
    if (error_count == 0) begin
      $display("permutation_unrank_top_tb: PASS");
    end else begin
      $display("permutation_unrank_top_tb: FAIL");
    end
    $finish;
  end
endmodule

`default_nettype wire
